// ===== rtl/bwc_pkg.sv =====
// ----------------------------------------------------------------------------
// bwc_pkg
// Shared constants for the balanced word crossover core.
// ----------------------------------------------------------------------------
package bwc_pkg;

    // width of every word field on the channels
    localparam int FIELD_BITS = 64;

    // default datapath width, at most FIELD_BITS
    localparam int DEF_WORD_BITS = 64;

    // default depth of the queue between front and back
    localparam int DEF_QUEUE_DEPTH = 2;

endpackage

// ===== rtl/bwc_in_if.sv =====
// ----------------------------------------------------------------------------
// bwc_in_if
// Input channel: one word from each parent plus the last-word mark per beat.
// ----------------------------------------------------------------------------
interface bwc_in_if import bwc_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] parent_a_word;
    logic [FIELD_BITS-1:0] parent_b_word;
    logic                  last_word;

    modport source (
        output valid,
        output parent_a_word,
        output parent_b_word,
        output last_word,
        input  ready
    );

    modport sink (
        input  valid,
        input  parent_a_word,
        input  parent_b_word,
        input  last_word,
        output ready
    );

endinterface

// ===== rtl/bwc_out_if.sv =====
// ----------------------------------------------------------------------------
// bwc_out_if
// Output channel: the two child words and the last-word mark per beat.
// ----------------------------------------------------------------------------
interface bwc_out_if import bwc_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] child_a_word;
    logic [FIELD_BITS-1:0] child_b_word;
    logic                  last_out;

    modport source (
        output valid,
        output child_a_word,
        output child_b_word,
        output last_out,
        input  ready
    );

    modport sink (
        input  valid,
        input  child_a_word,
        input  child_b_word,
        input  last_out,
        output ready
    );

endinterface

// ===== rtl/bwc_front.sv =====
// ----------------------------------------------------------------------------
// bwc_front
// Classifies one parent word pair: common bits, the alternating split of the
// differing bits into y (odd-numbered from the lsb) and z, and the word parity.
// ----------------------------------------------------------------------------
module bwc_front import bwc_pkg::*; #(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [WORD_BITS-1:0] i_parent_a,
    input  logic [WORD_BITS-1:0] i_parent_b,
    output logic [WORD_BITS-1:0] o_common,
    output logic [WORD_BITS-1:0] o_y,
    output logic [WORD_BITS-1:0] o_z,
    output logic                 o_odd
);

    localparam int LVLS = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] diff;
    logic [WORD_BITS-1:0] pre [LVLS+1];
    logic [WORD_BITS-1:0] excl;

    assign diff     = i_parent_a ^ i_parent_b;
    assign o_common = i_parent_a & i_parent_b;

    // log-depth inclusive prefix parity of the differing bits
    always_comb begin
        pre[0] = diff;
        for (int s = 0; s < LVLS; s++) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                if (i >= (1 << s)) begin
                    pre[s+1][i] = pre[s][i] ^ pre[s][i - (1 << s)];
                end else begin
                    pre[s+1][i] = pre[s][i];
                end
            end
        end
    end

    // parity of differing bits strictly below each position
    assign excl = {pre[LVLS][WORD_BITS-2:0], 1'b0};

    // even count below means this differing bit is the 1st, 3rd, 5th ...
    assign o_y   = diff & ~excl;
    assign o_z   = diff & excl;
    assign o_odd = pre[LVLS][WORD_BITS-1];

    // the split covers the differing bits exactly once
    a_split_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((o_y | o_z) == diff) && ((o_y & o_z) == '0))
        else $error("y/z split does not partition the differing bits");

    // prefix network agrees with a plain reduction
    a_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_odd == ^diff)
        else $error("prefix parity disagrees with word parity");

endmodule

// ===== rtl/bwc_queue.sv =====
// ----------------------------------------------------------------------------
// bwc_queue
// Small first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module bwc_queue import bwc_pkg::*; #(
    parameter int WIDTH = 3 * DEF_WORD_BITS + 2,
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // occupancy never exceeds the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

endmodule

// ===== rtl/bwc_back.sv =====
// ----------------------------------------------------------------------------
// bwc_back
// Applies the running turn bit to a classified word and holds the result
// in the output register until the consumer takes it.
// ----------------------------------------------------------------------------
module bwc_back import bwc_pkg::*; #(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  logic [WORD_BITS-1:0] i_common,
    input  logic [WORD_BITS-1:0] i_y,
    input  logic [WORD_BITS-1:0] i_z,
    input  logic                 i_odd,
    input  logic                 i_last,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [WORD_BITS-1:0] o_child_a,
    output logic [WORD_BITS-1:0] o_child_b,
    output logic                 o_last
);

    logic                 r_turn, n_turn;
    logic                 r_valid, n_valid;
    logic [WORD_BITS-1:0] r_child_a, n_child_a;
    logic [WORD_BITS-1:0] r_child_b, n_child_b;
    logic                 r_last, n_last;
    logic                 turn_now;

    // take the queue head when the output register is free or draining
    assign o_pop    = i_q_valid && (!r_valid || i_ready);
    assign turn_now = r_turn ^ i_odd;

    always_comb begin
        n_turn    = r_turn;
        n_valid   = r_valid && !i_ready;
        n_child_a = r_child_a;
        n_child_b = r_child_b;
        n_last    = r_last;
        if (o_pop) begin
            n_valid   = 1'b1;
            n_child_a = i_common | (turn_now ? i_z : i_y);
            n_child_b = i_common | (turn_now ? i_y : i_z);
            n_last    = i_last;
            n_turn    = i_last ? 1'b0 : turn_now;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_turn  <= n_turn;
            r_valid <= n_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_child_a <= n_child_a;
        r_child_b <= n_child_b;
        r_last    <= n_last;
    end

    assign o_valid   = r_valid;
    assign o_child_a = r_child_a;
    assign o_child_b = r_child_b;
    assign o_last    = r_last;

    // a new vector starts from turn zero
    a_turn_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_last |=> !r_turn)
        else $error("turn not cleared after last word");

    // an even word leaves the turn as it was
    a_turn_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && !i_last && !i_odd |=> r_turn == $past(r_turn))
        else $error("turn changed on even word");

endmodule

// ===== rtl/balanced_word_crossover_core.sv =====
// ----------------------------------------------------------------------------
// balanced_word_crossover_core
// Count-balancing uniform crossover of two parent bit vectors, one word a beat.
// ----------------------------------------------------------------------------
// Takes one word pair per cycle while the queue is not full and returns one
// child word pair per input beat, in order. Common bits go to both children;
// differing bits are dealt alternately from the lsb, and a turn bit, toggled
// by each odd-count word and cleared after a last word, picks which child
// gets the first share. The front computes the split with a log-depth xor
// prefix network in the same cycle the beat is accepted and writes it into a
// queue of QUEUE_DEPTH entries (two by default); the back applies the turn
// bit and registers the result. Sustained rate is one word per cycle while
// the consumer is ready. Only the low WORD_BITS bits of each parent word are
// used; higher child bits read as zero.
// ----------------------------------------------------------------------------
module balanced_word_crossover_core import bwc_pkg::*; #(
    parameter int WORD_BITS   = DEF_WORD_BITS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bwc_in_if.sink   i_in,
    bwc_out_if.source o_out
);

    localparam int Q_WIDTH = 3 * WORD_BITS + 2;

    logic [WORD_BITS-1:0] f_common, f_y, f_z;
    logic                 f_odd;
    logic                 q_full, q_valid, q_pop, push;
    logic [Q_WIDTH-1:0]   q_in, q_out;
    logic [WORD_BITS-1:0] b_common, b_y, b_z;
    logic                 b_odd, b_last;
    logic [WORD_BITS-1:0] child_a, child_b;

    // front: classify the incoming beat
    bwc_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_parent_a (i_in.parent_a_word[WORD_BITS-1:0]),
        .i_parent_b (i_in.parent_b_word[WORD_BITS-1:0]),
        .o_common   (f_common),
        .o_y        (f_y),
        .o_z        (f_z),
        .o_odd      (f_odd)
    );

    assign i_in.ready = !q_full;
    assign push       = i_in.valid && !q_full;
    assign q_in       = {f_common, f_y, f_z, f_odd, i_in.last_word};

    // queue between front and back
    bwc_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign {b_common, b_y, b_z, b_odd, b_last} = q_out;

    // back: apply turn and register the result
    bwc_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_common  (b_common),
        .i_y       (b_y),
        .i_z       (b_z),
        .i_odd     (b_odd),
        .i_last    (b_last),
        .o_pop     (q_pop),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_child_a (child_a),
        .o_child_b (child_b),
        .o_last    (o_out.last_out)
    );

    assign o_out.child_a_word = FIELD_BITS'(child_a);
    assign o_out.child_b_word = FIELD_BITS'(child_b);

endmodule
